FILE: rtl/core/rte_pkg.sv
// shared types, constants and the phase transition table for the rotary encoder block
`timescale 1ns / 1ps

package rte_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int STEPS_W     = 16;
    localparam int TICK_W      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int SHIFT_W     = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DETENT_SHIFT     = 2'd2;

    localparam logic [TICK_W-1:0]  DEBOUNCE_TICKS_RST   = 16'd50;
    localparam logic [TICK_W-1:0]  LONG_PRESS_TICKS_RST = 16'd1000;
    localparam logic [SHIFT_W-1:0] DETENT_SHIFT_RST     = 2'd2;
    localparam logic [SHIFT_W-1:0] DETENT_SHIFT_MAX     = 2'd2;
    localparam logic [TICK_W-1:0]  TICK_SAT             = 16'hFFFF;

    // request kinds carried on tuser
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // count change per phase transition, index {prev dt, prev clk, dt, clk}
    localparam logic signed [1:0] PHASE_STEP [16] = '{
        2'sd0, 2'sd1, -2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd0, 2'sd1,
        2'sd1, 2'sd0, 2'sd0, -2'sd1, 2'sd0, -2'sd1, 2'sd1, 2'sd0
    };

    typedef struct packed {
        logic tick;
        logic read;
        logic pin_clk;
        logic pin_dt;
        logic pin_sw;
    } rte_req_t;

    typedef struct packed {
        logic press_seen;
        logic release_seen;
        logic long_press_seen;
        logic button_level;
    } rte_btn_flags_t;

endpackage

FILE: rtl/core/rotary_encoder_with_button_top.sv
// top level of the rotary encoder decoder with button debounce
//
//   channel | direction | fields
//   s_      | in        | tuser: req_type; tdata: pin_clk, pin_dt, pin_sw
//   m_      | out       | tdata: detent_steps, press_seen, release_seen, long_press_seen,
//           |           |        button_level (read items only)
//   cfg_    | in        | debounce_ticks, long_press_ticks, detent_shift
//
// one item per cycle unless a read waits; an item passes through the input register,
// then the state update and result register
// ticks produce no result and never wait on the result side
// a read waits only while an earlier result is still not taken
// aresetn clears all but the payload registers, loads register defaults; no clearing pass
`timescale 1ns / 1ps

module rotary_encoder_with_button_top #(
    parameter int COUNT_BITS = rte_pkg::COUNT_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rte_pkg::IN_TDATA_W-1:0]    s_tdata,   // pin_clk, pin_dt, pin_sw, zero pad
    input  logic                              s_tuser,   // req_type

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // detent_steps[15:0], press_seen, release_seen, long_press_seen, button_level, zero pad
    output logic [rte_pkg::OUT_TDATA_W-1:0]   m_tdata,

    input  logic                              cfg_we,
    input  logic [rte_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rte_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    logic                              in_valid_reg;
    logic                              in_user_reg;
    logic [2:0]                        in_pins_reg;
    logic                              out_valid_reg;
    logic [rte_pkg::OUT_TDATA_W-1:0]   out_data_reg;

    logic [rte_pkg::TICK_W-1:0]        debounce_reg;
    logic [rte_pkg::TICK_W-1:0]        long_press_reg;
    logic [rte_pkg::SHIFT_W-1:0]       shift_reg;

    logic                              adv;
    rte_pkg::rte_req_t                 req;
    rte_pkg::rte_btn_flags_t           flags;
    logic signed [rte_pkg::STEPS_W-1:0] detent_steps;

    always_comb begin
        adv = in_valid_reg && (in_user_reg == rte_pkg::REQ_TICK || !out_valid_reg || m_tready);
        s_tready = !in_valid_reg || adv;

        req.tick    = adv && in_user_reg == rte_pkg::REQ_TICK;
        req.read    = adv && in_user_reg == rte_pkg::REQ_READ;
        req.pin_clk = in_pins_reg[0];
        req.pin_dt  = in_pins_reg[1];
        req.pin_sw  = in_pins_reg[2];

        m_tvalid = out_valid_reg;
        m_tdata  = out_data_reg;
    end

    rte_count #(
        .COUNT_BITS (COUNT_BITS)
    ) u_count (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .req          (req),
        .detent_shift (shift_reg),
        .detent_steps (detent_steps)
    );

    rte_button u_button (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .req              (req),
        .debounce_ticks   (debounce_reg),
        .long_press_ticks (long_press_reg),
        .flags            (flags)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            debounce_reg   <= rte_pkg::DEBOUNCE_TICKS_RST;
            long_press_reg <= rte_pkg::LONG_PRESS_TICKS_RST;
            shift_reg      <= rte_pkg::DETENT_SHIFT_RST;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (adv) begin
                in_valid_reg <= 1'b0;
            end

            if (req.read) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_we) begin
                case (cfg_index)
                    rte_pkg::CFG_DEBOUNCE_TICKS:   debounce_reg   <= cfg_wdata;
                    rte_pkg::CFG_LONG_PRESS_TICKS: long_press_reg <= cfg_wdata;
                    rte_pkg::CFG_DETENT_SHIFT:     shift_reg      <= cfg_wdata[rte_pkg::SHIFT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_user_reg <= s_tuser;
            in_pins_reg <= s_tdata[2:0];
        end
        if (req.read) begin
            out_data_reg <= {4'b0000, flags.button_level, flags.long_press_seen,
                             flags.release_seen, flags.press_seen, detent_steps};
        end
    end

endmodule

FILE: rtl/core/rte_count.sv
// quadrature phase decoding, saturating count accumulator and detent conversion
`timescale 1ns / 1ps

module rte_count #(
    parameter int COUNT_BITS = rte_pkg::COUNT_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  rte_pkg::rte_req_t                    req,
    input  logic [rte_pkg::SHIFT_W-1:0]          detent_shift,
    output logic signed [rte_pkg::STEPS_W-1:0]   detent_steps
);

    localparam int SW = (COUNT_BITS + 1 > rte_pkg::STEPS_W + 1) ? COUNT_BITS + 1
                                                                 : rte_pkg::STEPS_W + 1;
    localparam logic signed [SW-1:0] STEP_MAX = SW'(32767);
    localparam logic signed [SW-1:0] STEP_MIN = -SW'(32768);
    localparam logic signed [COUNT_BITS-1:0] ACC_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam logic signed [COUNT_BITS-1:0] ACC_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

    logic [1:0]                    phase_reg, phase_next;
    logic                          primed_reg, primed_next;
    logic signed [COUNT_BITS-1:0]  accum_reg, accum_next;
    logic signed [2:0]             rem_reg, rem_next;

    logic [1:0]                    cur_phase;
    logic signed [1:0]             step;
    logic [rte_pkg::SHIFT_W-1:0]   sh;
    logic signed [SW-1:0]          total, bias, adj, quot, rem_full;

    always_comb begin
        cur_phase = {req.pin_dt, req.pin_clk};
        step      = rte_pkg::PHASE_STEP[{phase_reg, cur_phase}];
        sh        = (detent_shift > rte_pkg::DETENT_SHIFT_MAX) ? rte_pkg::DETENT_SHIFT_MAX
                                                               : detent_shift;
        total     = SW'(accum_reg) + SW'(rem_reg);
        case (sh)
            2'd0:    bias = '0;
            2'd1:    bias = SW'(1);
            default: bias = SW'(3);
        endcase
        // bias negatives so the arithmetic shift truncates toward zero
        adj      = total[SW-1] ? total + bias : total;
        quot     = adj >>> sh;
        rem_full = total - (quot <<< sh);

        phase_next   = phase_reg;
        primed_next  = primed_reg;
        accum_next   = accum_reg;
        rem_next     = rem_reg;
        detent_steps = '0;

        if (req.tick) begin
            phase_next  = cur_phase;
            primed_next = 1'b1;
            if (primed_reg) begin
                if (step > 2'sd0) begin
                    if (accum_reg != ACC_MAX) accum_next = accum_reg + COUNT_BITS'(1);
                end else if (step < 2'sd0) begin
                    if (accum_reg != ACC_MIN) accum_next = accum_reg - COUNT_BITS'(1);
                end
            end
        end

        if (req.read && accum_reg != '0) begin
            accum_next = '0;
            rem_next   = rem_full[2:0];
            if (quot > STEP_MAX)      detent_steps = 16'sh7FFF;
            else if (quot < STEP_MIN) detent_steps = -16'sh8000;
            else                      detent_steps = quot[rte_pkg::STEPS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= '0;
            primed_reg <= 1'b0;
            accum_reg  <= '0;
            rem_reg    <= '0;
        end else begin
            phase_reg  <= phase_next;
            primed_reg <= primed_next;
            accum_reg  <= accum_next;
            rem_reg    <= rem_next;
        end
    end

endmodule

FILE: rtl/core/rte_button.sv
// push-button debounce with press, short release and long press flags
`timescale 1ns / 1ps

module rte_button (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rte_pkg::rte_req_t            req,
    input  logic [rte_pkg::TICK_W-1:0]   debounce_ticks,
    input  logic [rte_pkg::TICK_W-1:0]   long_press_ticks,
    output rte_pkg::rte_btn_flags_t      flags
);

    logic                        db_reg, db_next;
    logic                        press_reg, press_next;
    logic                        release_reg, release_next;
    logic                        long_reg, long_next;
    logic                        supp_reg, supp_next;
    logic [rte_pkg::TICK_W-1:0]  tsc_reg, tsc_next;
    logic [rte_pkg::TICK_W-1:0]  tsp_reg, tsp_next;

    logic                        raw;
    logic [rte_pkg::TICK_W-1:0]  tsc_bump, tsp_bump;

    always_comb begin
        raw      = !req.pin_sw;
        tsc_bump = (tsc_reg == rte_pkg::TICK_SAT) ? tsc_reg : tsc_reg + 16'd1;
        tsp_bump = (tsp_reg == rte_pkg::TICK_SAT) ? tsp_reg : tsp_reg + 16'd1;

        db_next      = db_reg;
        press_next   = press_reg;
        release_next = release_reg;
        long_next    = long_reg;
        supp_next    = supp_reg;
        tsc_next     = tsc_reg;
        tsp_next     = tsp_reg;

        if (req.tick) begin
            tsc_next = tsc_bump;
            tsp_next = tsp_bump;
            if (raw != db_reg) begin
                if (tsc_bump > debounce_ticks) begin
                    db_next  = raw;
                    tsc_next = '0;
                    if (raw) begin
                        press_next = 1'b1;
                        tsp_next   = '0;
                        long_next  = 1'b0;
                        supp_next  = 1'b0;
                    end else if (!supp_reg) begin
                        release_next = 1'b1;
                    end
                end
            end else if (db_reg && !long_reg) begin
                if (tsp_bump > long_press_ticks) begin
                    long_next = 1'b1;
                    supp_next = 1'b1;
                end
            end
        end

        // a read reports the flags and clears them; suppression stays with the hold
        if (req.read) begin
            press_next   = 1'b0;
            release_next = 1'b0;
            long_next    = 1'b0;
        end

        flags.press_seen      = press_reg;
        flags.release_seen    = release_reg;
        flags.long_press_seen = long_reg;
        flags.button_level    = db_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            db_reg      <= 1'b0;
            press_reg   <= 1'b0;
            release_reg <= 1'b0;
            long_reg    <= 1'b0;
            supp_reg    <= 1'b0;
            tsc_reg     <= '0;
            tsp_reg     <= '0;
        end else begin
            db_reg      <= db_next;
            press_reg   <= press_next;
            release_reg <= release_next;
            long_reg    <= long_next;
            supp_reg    <= supp_next;
            tsc_reg     <= tsc_next;
            tsp_reg     <= tsp_next;
        end
    end

`ifndef NO_ASSERTIONS
    // an accepted press always leaves the press flag set
    a_press_flagged: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(db_reg) |-> press_reg)
        else $error("debounced press without press flag");

    // a long press always arms release suppression
    a_long_supp: assert property (@(posedge aclk) disable iff (!aresetn)
        long_reg |-> supp_reg)
        else $error("long press flagged without release suppression");

    // a release flag only appears with the button released
    a_release_level: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(release_reg) |-> !db_reg)
        else $error("release flagged while button held");
`endif

endmodule
